// ----- rtl/scim_pkg.sv -----
// shared types, constants and defaults of the sparse int8 matrix multiply block
package scim_pkg;

    // default sizes of the dense store and accumulator bank
    localparam int MAX_COLS_DEF  = 64;
    localparam int MAX_INNER_DEF = 64;

    // field widths
    localparam int FUNC_W    = 2;
    localparam int ROW_W     = 6;
    localparam int COL_W     = 6;
    localparam int VAL_W     = 8;
    localparam int SUM_W     = 32;
    localparam int NCOLS_W   = 7;
    localparam int PROD_W    = 2 * VAL_W;

    // column count after reset
    localparam logic [NCOLS_W-1:0] NCOLS_RST = NCOLS_W'(64);

    // request function codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_NZ   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_EOR  = 2'd2;

    // request payload
    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic [ROW_W-1:0]        mat_row;
        logic [COL_W-1:0]        dense_col;
        logic signed [VAL_W-1:0] value;
    } scim_req_t;

    // result payload
    typedef struct packed {
        logic signed [SUM_W-1:0] row_sum;
        logic [COL_W-1:0]        out_col;
        logic                    last;
    } scim_res_t;

endpackage

// ----- rtl/scim_ram.sv -----
// generic single-write, single-read synchronous ram with registered read
module scim_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/sparse_csr_int8_matmul.sv -----
// top level of the int8 sparse-times-dense matrix multiply with 32-bit sums
//
//  channel  | signals                        | direction | payload
//  ---------+--------------------------------+-----------+-----------------------------
//  request  | item_valid, item_ready, item   | in        | func, mat_row, dense_col, value
//  result   | res_valid, res_ready, res      | out       | row_sum, out_col, last
//  config   | cfg_we, cfg_wdata              | in        | n_cols
//
// a load request writes the dense store when its row and column are in range; a nonzero
// request with an in-range row runs one multiply-accumulate per cycle over the clamped
// column count through the single read port of the accumulator ram, then a writeback;
// an end-of-row request emits one result per clamped column at one per cycle when res_ready stays high, via that port.
// reset clears control state and marks every accumulator as zero through valid bits;
// the dense store is not cleared. a stalled result holds in the output register while
// the next request may already be taken.
module sparse_csr_int8_matmul
    import scim_pkg::*;
#(
    parameter int MAX_COLS  = MAX_COLS_DEF,
    parameter int MAX_INNER = MAX_INNER_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [NCOLS_W-1:0]   cfg_wdata,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  scim_req_t            item,
    output logic                 res_valid,
    input  logic                 res_ready,
    output scim_res_t            res
);

    localparam int IDX_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CNT_W   = $clog2(MAX_COLS + 1);
    localparam int D_DEPTH = MAX_INNER * MAX_COLS;
    localparam int DA_W    = (D_DEPTH > 1) ? $clog2(D_DEPTH) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAC  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [NCOLS_W-1:0]      ncols_reg;
    logic [CNT_W-1:0]        cols_act;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [ROW_W-1:0]        row_reg, row_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    logic                    idx_last;

    logic [MAX_COLS-1:0]     acc_vld_reg, acc_vld_next;

    logic                    wb_vld_reg, wb_vld_next;
    logic [IDX_W-1:0]        wb_col_reg;

    logic                    pend_reg, pend_next;
    logic [IDX_W-1:0]        pend_col_reg;
    logic                    pend_vld_reg;
    logic                    pend_last_reg;

    logic                    out_vld_reg, out_vld_next;
    scim_res_t               out_reg;

    logic                    accept;
    logic                    emit_issue;
    logic                    move;
    logic                    row_ok;
    logic                    col_ok;

    logic                    d_we;
    logic [DA_W-1:0]         d_waddr;
    logic                    d_re;
    logic [DA_W-1:0]         d_raddr;
    logic [VAL_W-1:0]        d_rdata;

    logic                    a_we;
    logic [SUM_W-1:0]        a_wdata;
    logic                    a_re;
    logic [SUM_W-1:0]        a_rdata;

    logic signed [PROD_W-1:0] prod;
    logic [SUM_W-1:0]         acc_old;

    // column count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ncols_reg <= NCOLS_RST;
        end
        else if (cfg_we)
        begin
            ncols_reg <= cfg_wdata;
        end
    end

    // clamp column count to 1..MAX_COLS
    always_comb
    begin
        if (ncols_reg == '0)
        begin
            cols_act = CNT_W'(1);
        end
        else if (int'(ncols_reg) > MAX_COLS)
        begin
            cols_act = CNT_W'(MAX_COLS);
        end
        else
        begin
            cols_act = CNT_W'(ncols_reg);
        end
    end

    // handshake and range checks
    assign item_ready = (state_reg == ST_IDLE) && !wb_vld_reg && !pend_reg;
    assign accept     = item_valid && item_ready;
    assign row_ok     = int'(item.mat_row) < MAX_INNER;
    assign col_ok     = int'(item.dense_col) < MAX_COLS;
    assign idx_last   = (CNT_W'(idx_reg) + CNT_W'(1)) == cols_act;
    assign move       = pend_reg && (!out_vld_reg || res_ready);
    assign emit_issue = (state_reg == ST_EMIT) && (!pend_reg || move);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        row_next   = row_reg;
        val_next   = val_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    row_next = item.mat_row;
                    val_next = item.value;
                    idx_next = '0;
                    unique case (item.func)
                        FUNC_NZ:
                        begin
                            if (row_ok)
                            begin
                                state_next = ST_MAC;
                            end
                        end
                        FUNC_EOR:
                        begin
                            state_next = ST_EMIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MAC:
            begin
                idx_next = idx_reg + IDX_W'(1);
                if (idx_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (emit_issue)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                    if (idx_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
        val_reg <= val_next;
    end

    // dense store: load writes, multiply-accumulate reads
    assign d_we    = accept && (item.func == FUNC_LOAD) && row_ok && col_ok;
    assign d_waddr = DA_W'(item.mat_row) * DA_W'(MAX_COLS) + DA_W'(item.dense_col);
    assign d_re    = (state_reg == ST_MAC);
    assign d_raddr = DA_W'(row_reg) * DA_W'(MAX_COLS) + DA_W'(idx_reg);

    scim_ram #(
        .WIDTH (VAL_W),
        .DEPTH (D_DEPTH)
    ) u_dense_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (item.value),
        .re    (d_re),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    // accumulator bank: read for update or emit, write back the new sum
    assign a_re    = (state_reg == ST_MAC) || emit_issue;
    assign prod    = val_reg * $signed(d_rdata);
    assign acc_old = acc_vld_reg[wb_col_reg] ? a_rdata : '0;
    assign a_wdata = acc_old + {{(SUM_W - PROD_W){prod[PROD_W-1]}}, prod};
    assign a_we    = wb_vld_reg;

    scim_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_COLS)
    ) u_acc_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (wb_col_reg),
        .wdata (a_wdata),
        .re    (a_re),
        .raddr (idx_reg),
        .rdata (a_rdata)
    );

    // writeback stage tracking
    assign wb_vld_next = (state_reg == ST_MAC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_vld_reg <= 1'b0;
        end
        else
        begin
            wb_vld_reg <= wb_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wb_col_reg <= idx_reg;
    end

    // accumulator valid bits: set on writeback, cleared when a row is emitted
    always_comb
    begin
        acc_vld_next = acc_vld_reg;
        if (wb_vld_reg)
        begin
            acc_vld_next[wb_col_reg] = 1'b1;
        end
        if (emit_issue && idx_last)
        begin
            acc_vld_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_vld_reg <= '0;
        end
        else
        begin
            acc_vld_reg <= acc_vld_next;
        end
    end

    // pending emit read waiting for the output register
    always_comb
    begin
        pend_next = pend_reg;
        if (emit_issue)
        begin
            pend_next = 1'b1;
        end
        else if (move)
        begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_issue)
        begin
            pend_col_reg  <= idx_reg;
            pend_vld_reg  <= acc_vld_reg[idx_reg];
            pend_last_reg <= idx_last;
        end
    end

    // output register
    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (move)
        begin
            out_vld_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_reg.row_sum <= pend_vld_reg ? $signed(a_rdata) : '0;
            out_reg.out_col <= COL_W'(pend_col_reg);
            out_reg.last    <= pend_last_reg;
        end
    end

    assign res_valid = out_vld_reg;
    assign res       = out_reg;

    // no accumulator writeback overlaps a row emit
    a_no_wb_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !wb_vld_reg)
        else $error("accumulator writeback during row emit");

    // a pending emit read never shares the accumulator port with an update
    a_pend_excl: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg != ST_MAC) && !wb_vld_reg)
        else $error("pending emit read overlaps multiply-accumulate");

    // all accumulators read as zero once a row emit has finished issuing
    a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(state_reg == ST_EMIT) |-> (acc_vld_reg == '0))
        else $error("accumulators not cleared after row emit");

    // after a non-final result is taken, the rest of the row is still in flight
    a_row_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready && !res.last) |=>
            ((state_reg == ST_EMIT) || pend_reg || res_valid))
        else $error("row ended without a final result");

endmodule
